>>> rtl/core/vbpc_pkg.sv
// Package for the video beam position counter.
// Holds the request, result and update payload types, beam state type and code enums.
// No dependencies.
`default_nettype none

package vbpc_pkg;

  localparam int HPOS_W  = 8;
  localparam int VPOS_W  = 9;
  localparam int FRAME_W = 32;
  localparam int CYC_W   = 17;

  typedef enum logic [1:0] {
    OP_ADVANCE  = 2'd0,
    OP_RETREAT  = 2'd1,
    OP_END_LINE = 2'd2
  } vbpc_op_e;

  typedef enum logic [2:0] {
    FK_PAL_LONG          = 3'd0,
    FK_PAL_SHORT         = 3'd1,
    FK_NTSC_LONG_LL      = 3'd2,
    FK_NTSC_LONG_SL      = 3'd3,
    FK_NTSC_SHORT_LL     = 3'd4,
    FK_NTSC_SHORT_SL     = 3'd5
  } vbpc_fkind_e;

  typedef enum logic [0:0] {
    REG_TV_STANDARD = 1'b0,
    REG_INTERLACE   = 1'b1
  } vbpc_reg_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] count;
  } vbpc_in_t;

  typedef struct packed {
    logic [HPOS_W-1:0]  beam_h;
    logic [VPOS_W-1:0]  beam_v;
    logic [FRAME_W-1:0] frame_number;
    logic               long_frame;
    logic               long_line;
    logic [HPOS_W-1:0]  held_h;
    logic [VPOS_W-1:0]  held_v;
    logic [2:0]         frame_kind;
    logic [CYC_W-1:0]   cycles_in_frame;
  } vbpc_out_t;

  typedef struct packed {
    logic [HPOS_W-1:0] h;
    logic [VPOS_W-1:0] v;
    logic              lof;
    logic              lol;
  } vbpc_beam_t;

  typedef struct packed {
    vbpc_beam_t         beam;
    logic [FRAME_W-1:0] frame;
    logic               held_h_we;
    logic [HPOS_W-1:0]  held_h;
    logic               held_v_we;
    logic [VPOS_W-1:0]  held_v;
  } vbpc_upd_t;

endpackage

`default_nettype wire

>>> rtl/core/vbpc_move.sv
// Next-state logic of the beam counter for one request: move or end of line.
// Depends on vbpc_pkg.
`default_nettype none

module vbpc_move #(
  parameter int LINE_CYCLES_SHORT = 227,
  parameter int LINE_CYCLES_LONG  = 228,
  parameter int PAL_LINES_LONG    = 313,
  parameter int NTSC_LINES_LONG   = 263
) (
  input  vbpc_pkg::vbpc_beam_t         beam_i,
  input  logic [vbpc_pkg::FRAME_W-1:0] frame_i,
  input  logic                         ntsc_i,
  input  logic                         interlace_i,
  input  vbpc_pkg::vbpc_in_t           req_i,
  output vbpc_pkg::vbpc_upd_t          upd_o
);

  localparam int StepMax  = LINE_CYCLES_SHORT - 1;
  localparam int NumSteps = (255 + StepMax - 1) / StepMax;
  localparam int WrapW    = $clog2(NumSteps + 1);

  function automatic logic [9:0] lines_of(input logic ntsc, input logic lof);
    logic [9:0] n;
    n = ntsc ? 10'(NTSC_LINES_LONG) : 10'(PAL_LINES_LONG);
    return lof ? n : n - 10'd1;
  endfunction

  function automatic logic [8:0] len_of(input logic ntsc, input logic lol);
    return (ntsc && lol) ? 9'(LINE_CYCLES_LONG) : 9'(LINE_CYCLES_SHORT);
  endfunction

  vbpc_pkg::vbpc_beam_t            b;
  logic [WrapW-1:0]                wraps;
  logic                            back;
  logic [8:0]                      rem;
  logic [8:0]                      amt;
  logic [8:0]                      sum;
  logic [9:0]                      vn;
  logic [8:0]                      v9;
  logic                            hh_we;
  logic                            hv_we;
  logic [vbpc_pkg::HPOS_W-1:0]     hh;
  logic [vbpc_pkg::VPOS_W-1:0]     hv;

  always_comb begin
    b     = beam_i;
    wraps = '0;
    back  = 1'b0;
    rem   = '0;
    amt   = '0;
    sum   = '0;
    vn    = '0;
    v9    = '0;
    hh_we = 1'b0;
    hv_we = 1'b0;
    hh    = beam_i.h;
    hv    = '0;
    case (req_i.kind)
      vbpc_pkg::OP_ADVANCE: begin
        for (int i = 0; i < NumSteps; i++) begin
          if ({1'b0, req_i.count} > 9'(i * StepMax)) begin
            rem = {1'b0, req_i.count} - 9'(i * StepMax);
            amt = (rem > 9'(StepMax)) ? 9'(StepMax) : rem;
            sum = {1'b0, b.h} + amt;
            if (sum >= len_of(ntsc_i, b.lol)) begin
              sum = sum - len_of(ntsc_i, b.lol);
              if (ntsc_i) begin
                b.lol = ~b.lol;
              end
              vn = {1'b0, b.v} + 10'd1;
              if (vn >= lines_of(ntsc_i, b.lof)) begin
                wraps = wraps + WrapW'(1);
                if (interlace_i) begin
                  b.lof = ~b.lof;
                end
                vn = '0;
              end
              b.v = vn[8:0];
            end
            b.h = sum[7:0];
          end
        end
      end
      vbpc_pkg::OP_RETREAT: begin
        back = 1'b1;
        for (int i = 0; i < NumSteps; i++) begin
          if ({1'b0, req_i.count} > 9'(i * StepMax)) begin
            rem = {1'b0, req_i.count} - 9'(i * StepMax);
            amt = (rem > 9'(StepMax)) ? 9'(StepMax) : rem;
            if ({1'b0, b.h} < amt) begin
              if (ntsc_i) begin
                b.lol = ~b.lol;
              end
              sum = {1'b0, b.h} + len_of(ntsc_i, b.lol) - amt;
              if (b.v == '0) begin
                wraps = wraps + WrapW'(1);
                if (interlace_i) begin
                  b.lof = ~b.lof;
                end
                vn  = lines_of(ntsc_i, b.lof) - 10'd1;
                b.v = vn[8:0];
              end else begin
                b.v = b.v - 9'd1;
              end
            end else begin
              sum = {1'b0, b.h} - amt;
            end
            b.h = sum[7:0];
          end
        end
      end
      vbpc_pkg::OP_END_LINE: begin
        hh_we = 1'b1;
        hh    = b.h;
        b.h   = '0;
        v9    = b.v + 9'd1;
        if ({1'b0, v9} >= lines_of(ntsc_i, b.lof)) begin
          hv_we = 1'b1;
          hv    = v9;
          b.v   = '0;
          wraps = WrapW'(1);
          if (interlace_i) begin
            b.lof = ~b.lof;
          end
        end else begin
          b.v = v9;
        end
        if (ntsc_i) begin
          b.lol = ~b.lol;
        end
      end
      default: begin
        b = beam_i;
      end
    endcase
  end

  always_comb begin
    upd_o.beam      = b;
    upd_o.frame     = back ? frame_i - 32'(wraps) : frame_i + 32'(wraps);
    upd_o.held_h_we = hh_we;
    upd_o.held_h    = hh;
    upd_o.held_v_we = hv_we;
    upd_o.held_v    = hv;
  end

endmodule

`default_nettype wire

>>> rtl/core/vbpc_kind.sv
// Frame kind decode and cycle count of a frame of that kind.
// Depends on vbpc_pkg.
`default_nettype none

module vbpc_kind #(
  parameter int LINE_CYCLES_SHORT = 227,
  parameter int LINE_CYCLES_LONG  = 228,
  parameter int PAL_LINES_LONG    = 313,
  parameter int NTSC_LINES_LONG   = 263
) (
  input  logic                       ntsc_i,
  input  vbpc_pkg::vbpc_beam_t       beam_i,
  output logic [2:0]                 frame_kind_o,
  output logic [vbpc_pkg::CYC_W-1:0] cycles_o
);

  localparam int NtscHi       = (NTSC_LINES_LONG + 1) / 2;
  localparam int NtscLo       = NTSC_LINES_LONG / 2;
  localparam int CycPalLong   = PAL_LINES_LONG * LINE_CYCLES_SHORT;
  localparam int CycPalShort  = (PAL_LINES_LONG - 1) * LINE_CYCLES_SHORT;
  localparam int CycNtscLongL = NtscHi * LINE_CYCLES_LONG + NtscLo * LINE_CYCLES_SHORT;
  localparam int CycNtscLongS = NtscHi * LINE_CYCLES_SHORT + NtscLo * LINE_CYCLES_LONG;
  localparam int CycNtscShort = NtscLo * LINE_CYCLES_SHORT + NtscLo * LINE_CYCLES_LONG;

  vbpc_pkg::vbpc_fkind_e fk;

  always_comb begin
    if (!ntsc_i) begin
      fk = beam_i.lof ? vbpc_pkg::FK_PAL_LONG : vbpc_pkg::FK_PAL_SHORT;
    end else if (!beam_i.v[0] && beam_i.lol) begin
      fk = beam_i.lof ? vbpc_pkg::FK_NTSC_LONG_LL : vbpc_pkg::FK_NTSC_SHORT_LL;
    end else begin
      fk = beam_i.lof ? vbpc_pkg::FK_NTSC_LONG_SL : vbpc_pkg::FK_NTSC_SHORT_SL;
    end
  end

  always_comb begin
    case (fk)
      vbpc_pkg::FK_PAL_LONG:     cycles_o = vbpc_pkg::CYC_W'(CycPalLong);
      vbpc_pkg::FK_PAL_SHORT:    cycles_o = vbpc_pkg::CYC_W'(CycPalShort);
      vbpc_pkg::FK_NTSC_LONG_LL: cycles_o = vbpc_pkg::CYC_W'(CycNtscLongL);
      vbpc_pkg::FK_NTSC_LONG_SL: cycles_o = vbpc_pkg::CYC_W'(CycNtscLongS);
      default:                   cycles_o = vbpc_pkg::CYC_W'(CycNtscShort);
    endcase
  end

  assign frame_kind_o = fk;

endmodule

`default_nettype wire

>>> rtl/core/video_beam_position_counter.sv
// Top level of the video beam position counter: beam state, configuration and result register.
// Depends on vbpc_pkg, vbpc_move and vbpc_kind.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      in_valid_i / in_ready_o       in_data_i  (vbpc_in_t)
//   out       output     out_valid_o / out_ready_i     out_data_o (vbpc_out_t)
//   cfg       input      cfg_we_i                      cfg_index_i, cfg_wdata_i
//
// One request is taken per clock unless output stalls; its result is registered next cycle.
// The beam state is updated in the same cycle through the move logic.
// A request is taken while the result register is empty or its result is taken that cycle.
// A stalled result holds the input side after one buffered result.
// Reset puts the beam at line zero, cycle zero, in PAL with the held line at the last PAL line.
`default_nettype none

module video_beam_position_counter #(
  parameter int LINE_CYCLES_SHORT = 227,
  parameter int LINE_CYCLES_LONG  = 228,
  parameter int PAL_LINES_LONG    = 313,
  parameter int NTSC_LINES_LONG   = 263
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vbpc_pkg::vbpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vbpc_pkg::vbpc_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [0:0]          cfg_wdata_i
);

  vbpc_pkg::vbpc_beam_t         beam_q, beam_d;
  logic [vbpc_pkg::FRAME_W-1:0] frame_q, frame_d;
  logic [vbpc_pkg::HPOS_W-1:0]  held_h_q, held_h_d;
  logic [vbpc_pkg::VPOS_W-1:0]  held_v_q, held_v_d;
  logic                         ntsc_q, ntsc_d;
  logic                         interlace_q, interlace_d;
  logic                         out_valid_q, out_valid_d;
  vbpc_pkg::vbpc_out_t          out_q, out_d;
  vbpc_pkg::vbpc_upd_t          upd;
  logic [2:0]                   frame_kind;
  logic [vbpc_pkg::CYC_W-1:0]   cycles;
  logic                         accept;
  logic [vbpc_pkg::HPOS_W-1:0]  held_h_nx;
  logic [vbpc_pkg::VPOS_W-1:0]  held_v_nx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  vbpc_move #(
    .LINE_CYCLES_SHORT(LINE_CYCLES_SHORT),
    .LINE_CYCLES_LONG (LINE_CYCLES_LONG),
    .PAL_LINES_LONG   (PAL_LINES_LONG),
    .NTSC_LINES_LONG  (NTSC_LINES_LONG)
  ) u_move (
    .beam_i     (beam_q),
    .frame_i    (frame_q),
    .ntsc_i     (ntsc_q),
    .interlace_i(interlace_q),
    .req_i      (in_data_i),
    .upd_o      (upd)
  );

  vbpc_kind #(
    .LINE_CYCLES_SHORT(LINE_CYCLES_SHORT),
    .LINE_CYCLES_LONG (LINE_CYCLES_LONG),
    .PAL_LINES_LONG   (PAL_LINES_LONG),
    .NTSC_LINES_LONG  (NTSC_LINES_LONG)
  ) u_kind (
    .ntsc_i      (ntsc_q),
    .beam_i      (upd.beam),
    .frame_kind_o(frame_kind),
    .cycles_o    (cycles)
  );

  assign held_h_nx = upd.held_h_we ? upd.held_h : held_h_q;
  assign held_v_nx = upd.held_v_we ? upd.held_v : held_v_q;

  always_comb begin
    beam_d      = beam_q;
    frame_d     = frame_q;
    held_h_d    = held_h_q;
    held_v_d    = held_v_q;
    ntsc_d      = ntsc_q;
    interlace_d = interlace_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      beam_d      = upd.beam;
      frame_d     = upd.frame;
      held_h_d    = held_h_nx;
      held_v_d    = held_v_nx;
      out_valid_d = 1'b1;
    end
    if (cfg_we_i) begin
      unique case (vbpc_pkg::vbpc_reg_e'(cfg_index_i))
        vbpc_pkg::REG_TV_STANDARD: begin
          ntsc_d     = cfg_wdata_i[0];
          beam_d.lol = 1'b0;
          held_v_d   = cfg_wdata_i[0] ? vbpc_pkg::VPOS_W'(NTSC_LINES_LONG - 1)
                                      : vbpc_pkg::VPOS_W'(PAL_LINES_LONG - 1);
        end
        vbpc_pkg::REG_INTERLACE: begin
          interlace_d = cfg_wdata_i[0];
        end
      endcase
    end
  end

  always_comb begin
    out_d.beam_h          = upd.beam.h;
    out_d.beam_v          = upd.beam.v;
    out_d.frame_number    = upd.frame;
    out_d.long_frame      = upd.beam.lof;
    out_d.long_line       = upd.beam.lol;
    out_d.held_h          = held_h_nx;
    out_d.held_v          = held_v_nx;
    out_d.frame_kind      = frame_kind;
    out_d.cycles_in_frame = cycles;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q      <= '0;
      frame_q     <= '0;
      held_h_q    <= '0;
      held_v_q    <= vbpc_pkg::VPOS_W'(PAL_LINES_LONG - 1);
      ntsc_q      <= 1'b0;
      interlace_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      beam_q      <= beam_d;
      frame_q     <= frame_d;
      held_h_q    <= held_h_d;
      held_v_q    <= held_v_d;
      ntsc_q      <= ntsc_d;
      interlace_q <= interlace_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  a_end_line_clears_h: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.kind == vbpc_pkg::OP_END_LINE) |=> (out_data_o.beam_h == '0))
    else $error("end of line did not return the beam to cycle zero");

  a_held_h_only_on_end_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && in_data_i.kind == vbpc_pkg::OP_END_LINE) |=> $stable(held_h_q))
    else $error("held horizontal position changed without an end of line");

endmodule

`default_nettype wire

>>> tb/tb_video_beam_position_counter.sv
// Self-checking testbench for the video beam position counter.
// Depends on vbpc_pkg and video_beam_position_counter; predicts every result in SystemVerilog.
// Directed beam moves in PAL and NTSC, then random walks around the frame boundary.
`default_nettype none

module tb_video_beam_position_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import vbpc_pkg::*;

  localparam int LINE_SHORT = 227;
  localparam int LINE_LONG  = 228;
  localparam int PAL_LINES  = 313;
  localparam int NTSC_LINES = 263;
  localparam int NTSC_HI    = (NTSC_LINES + 1) / 2;
  localparam int NTSC_LO    = NTSC_LINES / 2;
  localparam int SETTLE     = 4;
  localparam int WATCHDOG   = 3000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  vbpc_in_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  vbpc_out_t out_data_o;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic      cfg_wdata = 1'b0;

  video_beam_position_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  int          cur_h = 0;
  int          cur_v = 0;
  int          hold_h = 0;
  int          hold_v = PAL_LINES - 1;
  logic [31:0] frame_cnt = '0;
  logic        long_frm = 1'b0;
  logic        long_ln = 1'b0;
  logic        std_ntsc = 1'b0;
  logic        ilace_on = 1'b0;

  vbpc_out_t expected_beam[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  logic      calm = 1'b0;

  function automatic int line_cycles();
    return (std_ntsc && long_ln) ? LINE_LONG : LINE_SHORT;
  endfunction

  function automatic int lines_in_frame();
    int base;
    base = std_ntsc ? NTSC_LINES : PAL_LINES;
    return long_frm ? base : base - 1;
  endfunction

  function automatic void next_frame();
    frame_cnt = frame_cnt + 32'd1;
    if (ilace_on) long_frm = ~long_frm;
  endfunction

  function automatic void move_forward(int n);
    int left, step, h;
    left = n;
    while (left > 0) begin
      step = (left < LINE_SHORT - 1) ? left : LINE_SHORT - 1;
      h = cur_h + step;
      left -= step;
      if (h >= line_cycles()) begin
        h -= line_cycles();
        if (std_ntsc) long_ln = ~long_ln;
        cur_v++;
        if (cur_v >= lines_in_frame()) begin
          next_frame();
          cur_v = 0;
        end
      end
      cur_h = h & 'hFF;
    end
  endfunction

  function automatic void move_back(int n);
    int left, step, h;
    left = n;
    while (left > 0) begin
      step = (left < LINE_SHORT - 1) ? left : LINE_SHORT - 1;
      h = cur_h - step;
      left -= step;
      if (h < 0) begin
        if (std_ntsc) long_ln = ~long_ln;
        h += line_cycles();
        if (cur_v == 0) begin
          frame_cnt = frame_cnt - 32'd1;
          if (ilace_on) long_frm = ~long_frm;
          cur_v = (lines_in_frame() - 1) & 'h1FF;
        end else begin
          cur_v--;
        end
      end
      cur_h = h & 'hFF;
    end
  endfunction

  function automatic void end_line();
    hold_h = cur_h;
    cur_h = 0;
    cur_v = (cur_v + 1) & 'h1FF;
    if (cur_v > lines_in_frame() - 1) begin
      hold_v = cur_v;
      cur_v = 0;
      next_frame();
    end
    if (std_ntsc) long_ln = ~long_ln;
  endfunction

  function automatic vbpc_fkind_e frame_kind_now();
    if (!std_ntsc) return long_frm ? FK_PAL_LONG : FK_PAL_SHORT;
    if ((cur_v % 2) == 0 && long_ln) return long_frm ? FK_NTSC_LONG_LL : FK_NTSC_SHORT_LL;
    return long_frm ? FK_NTSC_LONG_SL : FK_NTSC_SHORT_SL;
  endfunction

  function automatic int frame_cycles(vbpc_fkind_e k);
    case (k)
      FK_PAL_LONG:     return PAL_LINES * LINE_SHORT;
      FK_PAL_SHORT:    return (PAL_LINES - 1) * LINE_SHORT;
      FK_NTSC_LONG_LL: return NTSC_HI * LINE_LONG + NTSC_LO * LINE_SHORT;
      FK_NTSC_LONG_SL: return NTSC_HI * LINE_SHORT + NTSC_LO * LINE_LONG;
      default:         return NTSC_LO * (LINE_SHORT + LINE_LONG);
    endcase
  endfunction

  function automatic vbpc_out_t predict_beam(vbpc_in_t req);
    vbpc_out_t   r;
    vbpc_fkind_e fk;
    case (req.kind)
      OP_ADVANCE:  move_forward(int'(req.count));
      OP_RETREAT:  move_back(int'(req.count));
      OP_END_LINE: end_line();
      default: ;
    endcase
    fk = frame_kind_now();
    r.beam_h          = cur_h[HPOS_W-1:0];
    r.beam_v          = cur_v[VPOS_W-1:0];
    r.frame_number    = frame_cnt;
    r.long_frame      = long_frm;
    r.long_line       = long_ln;
    r.held_h          = hold_h[HPOS_W-1:0];
    r.held_v          = hold_v[VPOS_W-1:0];
    r.frame_kind      = fk;
    r.cycles_in_frame = CYC_W'(frame_cycles(fk));
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    vbpc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (expected_beam.size() == 0) begin
          report_mismatch("result with no request pending", out_data_o.beam_h, 0);
        end else begin
          want = expected_beam.pop_front();
          if (out_data_o.beam_h !== want.beam_h)
            report_mismatch("beam_h", out_data_o.beam_h, want.beam_h);
          if (out_data_o.beam_v !== want.beam_v)
            report_mismatch("beam_v", out_data_o.beam_v, want.beam_v);
          if (out_data_o.frame_number !== want.frame_number)
            report_mismatch("frame_number", out_data_o.frame_number, want.frame_number);
          if (out_data_o.long_frame !== want.long_frame)
            report_mismatch("long_frame", out_data_o.long_frame, want.long_frame);
          if (out_data_o.long_line !== want.long_line)
            report_mismatch("long_line", out_data_o.long_line, want.long_line);
          if (out_data_o.held_h !== want.held_h)
            report_mismatch("held_h", out_data_o.held_h, want.held_h);
          if (out_data_o.held_v !== want.held_v)
            report_mismatch("held_v", out_data_o.held_v, want.held_v);
          if (out_data_o.frame_kind !== want.frame_kind)
            report_mismatch("frame_kind", out_data_o.frame_kind, want.frame_kind);
          if (out_data_o.cycles_in_frame !== want.cycles_in_frame)
            report_mismatch("cycles_in_frame", out_data_o.cycles_in_frame,
                            want.cycles_in_frame);
        end
      end
      if (in_valid && in_ready_o) expected_beam.push_back(predict_beam(in_data));
      if ((out_valid_o && out_ready) || (in_valid && in_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("tb_video_beam_position_counter: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [7:0] count);
    vbpc_in_t req;
    int       gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.kind = kind;
    req.count = count;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_beam.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(vbpc_reg_e idx, logic val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_TV_STANDARD) begin
      std_ntsc = val;
      long_ln = 1'b0;
      hold_v = (val ? NTSC_LINES : PAL_LINES) - 1;
    end else begin
      ilace_on = val;
    end
    @(posedge clk_i);
  endtask

  task automatic test_idle_state();
    send_request(OP_UNUSED, 8'hFF);
    send_request(OP_ADVANCE, 8'd0);
    send_request(OP_RETREAT, 8'd0);
    send_request(OP_UNUSED, 8'd0);
  endtask

  task automatic test_pal_beam();
    send_request(OP_ADVANCE, 8'd226);
    send_request(OP_ADVANCE, 8'd1);
    send_request(OP_ADVANCE, 8'd255);
    send_request(OP_RETREAT, 8'd255);
    send_request(OP_RETREAT, 8'd226);
    send_request(OP_RETREAT, 8'd226);
    send_request(OP_END_LINE, 8'd0);
    send_request(OP_END_LINE, 8'd17);
    drain();
    write_reg(REG_INTERLACE, 1'b1);
    send_request(OP_RETREAT, 8'd1);
    send_request(OP_RETREAT, 8'd1);
    send_request(OP_END_LINE, 8'd0);
    send_request(OP_RETREAT, 8'd1);
  endtask

  task automatic test_ntsc_beam();
    drain();
    write_reg(REG_TV_STANDARD, 1'b1);
    send_request(OP_ADVANCE, 8'd226);
    send_request(OP_END_LINE, 8'd0);
    send_request(OP_END_LINE, 8'd0);
    send_request(OP_ADVANCE, 8'd227);
    send_request(OP_RETREAT, 8'd255);
    send_request(OP_RETREAT, 8'd226);
    send_request(OP_END_LINE, 8'd0);
    drain();
    write_reg(REG_INTERLACE, 1'b0);
    write_reg(REG_TV_STANDARD, 1'b0);
    send_request(OP_ADVANCE, 8'd200);
  endtask

  // Keeps the beam within reach of the frame boundary so both wraps keep occurring.
  task automatic send_random_request();
    int         r, c, to_end;
    logic [1:0] kind;
    logic [7:0] count;
    to_end = lines_in_frame() - cur_v;
    r = $urandom_range(0, 99);
    if (cur_v > 40 && to_end > 40 && cur_v < to_end) begin
      kind = (r < 75) ? OP_RETREAT : (r < 90) ? OP_ADVANCE : OP_END_LINE;
    end else if (cur_v > 40 && to_end > 40) begin
      kind = (r < 45) ? OP_END_LINE : (r < 75) ? OP_ADVANCE : OP_RETREAT;
    end else begin
      kind = (r < 35) ? OP_ADVANCE : (r < 65) ? OP_RETREAT : (r < 95) ? OP_END_LINE : OP_UNUSED;
    end
    c = $urandom_range(0, 99);
    if (c < 65) count = 8'($urandom_range(0, 226));
    else if (c < 80) count = 8'd226;
    else if (c < 90) count = 8'($urandom_range(0, 3));
    else count = 8'($urandom_range(227, 255));
    send_request(kind, count);
  endtask

  task automatic test_random_beam(logic ntsc, logic ilace, logic steady, int n);
    drain();
    calm = steady;
    write_reg(REG_TV_STANDARD, ntsc);
    write_reg(REG_INTERLACE, ilace);
    repeat (n) send_random_request();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_state();
    test_pal_beam();
    test_ntsc_beam();
    test_random_beam(1'b0, 1'b0, 1'b0, 90);
    test_random_beam(1'b1, 1'b1, 1'b0, 90);
    test_random_beam(1'b0, 1'b1, 1'b1, 90);
    test_random_beam(1'b1, 1'b0, 1'b0, 90);
    test_random_beam(1'b1, 1'b1, 1'b0, 90);
    drain();
    calm = 1'b0;
    if (expected_beam.size() != 0) report_mismatch("results never returned",
                                                   0, expected_beam.size());
    if (errors == 0) begin
      $display("tb_video_beam_position_counter: PASS");
    end else begin
      $display("tb_video_beam_position_counter: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> video_beam_position_counter.f
rtl/core/vbpc_pkg.sv
rtl/core/vbpc_move.sv
rtl/core/vbpc_kind.sv
rtl/core/video_beam_position_counter.sv
tb/tb_video_beam_position_counter.sv
